// File: rtl/assert_macros.svh
// Assertion macros shared by the duty-cycle accountant RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock outside reset.
`define DCPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property whose consequence must hold in the clock after its trigger.
`define DCPA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/dcpa_pkg.sv
// Types and constants of the duty-cycle power accountant.
`default_nettype none
package dcpa_pkg;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int DIV_NW     = 40;
	localparam int DIV_DW     = 24;
	localparam int DIV_CNT_W  = 6;
	localparam int MUL_AW     = 32;
	localparam int MUL_BW     = 24;
	localparam int MUL_PW     = 34;
	localparam int MUL_CNT_W  = 5;

	localparam logic [23:0] DEF_INTERVAL   = 24'd1000;
	localparam logic [16:0] ACTIVE_UA      = 17'd60000;
	localparam logic [13:0] DUTY_FULL      = 14'd10000;
	localparam logic [23:0] DEEP_TX_MS     = 24'd500;
	localparam logic [39:0] DEEP_TX_CHARGE = 40'd40000000;
	localparam logic [39:0] LIGHT_SLEEP_UA = 40'd2000;
	localparam logic [39:0] DEEP_SLEEP_UA  = 40'd10;
	localparam logic [28:0] LIGHT_RATIO    = 29'd29;
	localparam logic [3:0]  DUTY_LAST_STEP = 4'd9;
	localparam logic [1:0]  DUTY_LAST_DIG  = 2'd3;

	localparam logic [1:0] PM_ACTIVE = 2'd0;
	localparam logic [1:0] PM_LIGHT  = 2'd1;
	localparam logic [1:0] ROLE_END  = 2'd0;
	localparam logic       KIND_TICK = 1'b0;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_ROLE = 2'd1;
	localparam logic [1:0] STAT_NO_ROUTE = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POWER_MODE     = 3'd0,
		CFG_LIGHT_INTERVAL = 3'd1,
		CFG_LIGHT_WINDOW   = 3'd2,
		CFG_DEEP_INTERVAL  = 3'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_DIV_A, S_DIV_E, S_LPREP, S_MUL, S_LFIN,
		S_DUTY_GO, S_DUTY_WAIT, S_OUT, S_EST_BASE, S_EST_NUM, S_EST_GO, S_EST_WAIT
	} dcpa_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;
endpackage
`default_nettype wire

// File: rtl/dcpa_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module dcpa_div import dcpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output unit_stat_t        stat,
	output logic [DIV_NW-1:0] quot,
	output logic [DIV_DW-1:0] rem
);
	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NW-1:0]    num_q;
	logic [DIV_DW-1:0]    rem_q, den_q;
	logic [DIV_DW:0]      shifted, diff;
	logic                 fits;

	assign shifted = {rem_q, num_q[DIV_NW-1]};
	assign fits    = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NW-2:0], fits};
			rem_q <= fits ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = num_q;
	assign rem       = rem_q;
endmodule
`default_nettype wire

// File: rtl/dcpa_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module dcpa_mul import dcpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MUL_AW-1:0] a,
	input  logic [MUL_BW-1:0] b,
	output unit_stat_t        stat,
	output logic [MUL_PW-1:0] prod
);
	logic                 busy_q, done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MUL_AW-1:0]    mplier_q;
	logic [MUL_PW-1:0]    mcand_q, acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MUL_CNT_W'(MUL_AW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= MUL_PW'(b);
			mplier_q <= a;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[MUL_PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MUL_AW-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;
endmodule
`default_nettype wire

// File: rtl/dcpa_duty.sv
// Decimal digit-serial duty ratio: floor(active * 10000 / total).
`default_nettype none
module dcpa_duty import dcpa_pkg::*; #(
	parameter int CW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] active,
	input  logic [CW-1:0] sleep,
	output unit_stat_t    stat,
	output logic [13:0]   duty
);
	logic          busy_q, prep_q, done_q;
	logic [3:0]    step_q;
	logic [1:0]    digit_q;
	logic [CW-1:0] t_q, r_q, tr_q, nr_q;
	logic [3:0]    d_q;
	logic [13:0]   q_q;
	logic [CW-1:0] t_in, nr_nx;
	logic          trivial, take;
	logic [3:0]    d_nx;

	assign t_in    = active + sleep;
	assign trivial = (t_in == '0) || (active >= t_in);
	assign take    = nr_q >= tr_q;
	assign nr_nx   = take ? nr_q - tr_q : nr_q + r_q;
	assign d_nx    = d_q + 4'(take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			prep_q  <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
			digit_q <= '0;
		end else if (start) begin
			busy_q  <= !trivial;
			prep_q  <= !trivial;
			done_q  <= trivial;
			digit_q <= '0;
		end else if (busy_q && prep_q) begin
			prep_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == DUTY_LAST_STEP) begin
				prep_q  <= 1'b1;
				digit_q <= digit_q + 1'b1;
				if (digit_q == DUTY_LAST_DIG) begin
					busy_q <= 1'b0;
					prep_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			t_q <= t_in;
			r_q <= active;
			q_q <= trivial ? DUTY_FULL : '0;
		end else if (busy_q && prep_q) begin
			tr_q <= t_q - r_q;
			nr_q <= '0;
			d_q  <= '0;
		end else if (busy_q) begin
			nr_q <= nr_nx;
			d_q  <= d_nx;
			if (step_q == DUTY_LAST_STEP) begin
				q_q <= 14'(q_q * 14'd10 + 14'(d_nx));
				r_q <= nr_nx;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign duty      = q_q;
endmodule
`default_nettype wire

// File: rtl/duty_cycle_power_accountant_unit.sv
// Top level of the duty-cycle power accountant.
//
// Input channel (in_valid/in_ready): one beat is a tick (mode 0) carrying
// now_ms and node_role, or a deep-sleep request (mode 1). Every beat gives
// exactly one result beat on the output channel (out_valid/out_ready).
// Config channel (cfg_valid/cfg_ready): cfg_index selects the power mode,
// the light-sleep period, the listen window or the deep-sleep interval;
// write while idle.
// One item at a time. A tick outside the light-sleep split waits on the
// decimal duty unit (4 digits of 10 steps). A light-sleep tick adds two
// 40-bit serial divisions and a 32-bit serial multiply before that.
// A config write recomputes the current estimate, outside active mode
// through the same divider, holding both ready lines low meanwhile.
// The result sits in an output register: the next beat is accepted while it
// waits, and a stalled receiver only holds the following result back.
// Reset restores the register defaults and clears all accumulators.
`default_nettype none
`include "assert_macros.svh"
module duty_cycle_power_accountant_unit import dcpa_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [31:0]           now_ms,
	input  logic [1:0]            node_role,
	input  logic                  routing_is_gradient,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [7:0]            sleep_events,
	output logic [7:0]            wake_events,
	output logic [23:0]           sleep_request_ms,
	output logic [31:0]           sleep_total,
	output logic [31:0]           active_time_ms,
	output logic [31:0]           sleep_time_ms,
	output logic [13:0]           duty_basis_points,
	output logic [16:0]           estimated_ua,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	dcpa_state_t state_q, state_nx;

	logic [1:0]  pm_q;
	logic [23:0] li_q, lw_q, di_q;
	logic [31:0] last_q;
	logic        phase_q;
	logic [COUNT_WIDTH-1:0] act_q, slp_q, sc_q;
	logic [13:0] duty_q;
	logic [16:0] est_q;

	logic        kind_q, grad_q;
	logic [31:0] now_q, a_q, delta_q;
	logic [1:0]  role_q;
	logic [31:0] qa_q, qe_q, qa1_q;
	logic [23:0] ma_q, me_q, ma1_q;
	logic [1:0]  res_status_q;
	logic [7:0]  res_sl_q, res_wk_q;
	logic [23:0] res_req_q;
	logic [28:0] base_q;
	logic [39:0] est_num_q;
	logic [23:0] est_den_q;

	logic        out_valid_q;
	logic [1:0]  o_status_q;
	logic [7:0]  o_sl_q, o_wk_q;
	logic [23:0] o_req_q;
	logic [31:0] o_total_q, o_act_q, o_slp_q;
	logic [13:0] o_duty_q;
	logic [16:0] o_est_q;

	logic in_take, cfg_take, div_start, mul_start, duty_start, out_load;
	unit_stat_t div_stat, mul_stat, duty_stat;
	logic [DIV_NW-1:0] div_num, div_quot;
	logic [DIV_DW-1:0] div_den, div_rem;
	logic [MUL_PW-1:0] prod;
	logic [13:0] duty_res;

	logic [23:0] eff_i, eff_w, me1, min_e, min_a, deep_s;
	logic        advanced, light_go, end_node, wrap_a, wnd_ok, a_in_win, deep_ok;
	logic [33:0] wk_run, sl_run, wk_all, sl_all, act_add, slp_add;

	assign eff_i    = (li_q == '0) ? DEF_INTERVAL : li_q;
	assign eff_w    = (lw_q > eff_i) ? eff_i : lw_q;
	assign end_node = role_q == ROLE_END;
	assign advanced = now_q > a_q;
	assign light_go = (kind_q == KIND_TICK) && advanced && (pm_q == PM_LIGHT) && end_node;
	assign deep_ok  = (pm_q != PM_ACTIVE) && (pm_q != PM_LIGHT) && end_node;
	assign deep_s   = (di_q > DEEP_TX_MS) ? di_q - DEEP_TX_MS : '0;

	assign wrap_a   = ({1'b0, ma_q} + 25'd1) == {1'b0, eff_i};
	assign me1      = (me_q != '0) ? me_q - 24'd1 : eff_i - 24'd1;
	assign wnd_ok   = (eff_w != '0) && (eff_w < eff_i);
	assign a_in_win = ma_q < eff_w;
	assign min_e    = (me_q < eff_w) ? me_q : eff_w;
	assign min_a    = (ma_q < eff_w) ? ma_q : eff_w;
	assign wk_run   = 34'(qe_q) + 34'(me_q != '0) - 34'(qa1_q) - 34'(ma1_q != '0);
	assign sl_run   = 34'(qe_q) + 34'(me_q > eff_w) - 34'(qa1_q) - 34'(ma1_q > eff_w);
	assign wk_all   = 34'(a_in_win && phase_q) + (wnd_ok ? wk_run : '0);
	assign sl_all   = 34'(!a_in_win && !phase_q) + (wnd_ok ? sl_run : '0);
	assign act_add  = prod + 34'(min_e) - 34'(min_a);
	assign slp_add  = 34'(delta_q) - act_add;

	assign div_num = (state_q == S_EST_GO) ? est_num_q :
		(state_q == S_DISP) ? DIV_NW'(a_q) : DIV_NW'(now_q);
	assign div_den = (state_q == S_EST_GO) ? est_den_q : eff_i;

	dcpa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .stat(div_stat), .quot(div_quot), .rem(div_rem)
	);

	dcpa_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(qe_q - qa_q),
		.b(eff_w), .stat(mul_stat), .prod(prod)
	);

	dcpa_duty #(.CW(COUNT_WIDTH)) u_duty (
		.clk(clk), .arst_n(arst_n), .start(duty_start), .active(act_q),
		.sleep(slp_q), .stat(duty_stat), .duty(duty_res)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_nx = S_DISP;
				else if (cfg_valid && cfg_index <= CFG_DEEP_INTERVAL)
					state_nx = S_EST_BASE;
			end
			S_DISP: begin
				if (kind_q != KIND_TICK)
					state_nx = S_OUT;
				else if (light_go)
					state_nx = S_DIV_A;
				else
					state_nx = S_DUTY_GO;
			end
			S_DIV_A:     if (div_stat.done) state_nx = S_DIV_E;
			S_DIV_E:     if (div_stat.done) state_nx = S_LPREP;
			S_LPREP:     state_nx = S_MUL;
			S_MUL:       if (mul_stat.done) state_nx = S_LFIN;
			S_LFIN:      state_nx = S_DUTY_GO;
			S_DUTY_GO:   state_nx = S_DUTY_WAIT;
			S_DUTY_WAIT: if (duty_stat.done) state_nx = S_OUT;
			S_OUT:       if (!out_valid_q || out_ready) state_nx = S_IDLE;
			S_EST_BASE:  state_nx = (pm_q == PM_ACTIVE) ? S_IDLE : S_EST_NUM;
			S_EST_NUM:   state_nx = S_EST_GO;
			S_EST_GO:    state_nx = S_EST_WAIT;
			S_EST_WAIT:  if (div_stat.done) state_nx = S_IDLE;
			default:     state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = state_q == S_IDLE;
		cfg_ready  = (state_q == S_IDLE) && !in_valid;
		div_start  = ((state_q == S_DISP) && light_go) ||
			((state_q == S_DIV_A) && div_stat.done) || (state_q == S_EST_GO);
		mul_start  = state_q == S_LPREP;
		duty_start = state_q == S_DUTY_GO;
		out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready);
	end

	assign in_take  = in_valid && in_ready;
	assign cfg_take = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			pm_q        <= PM_ACTIVE;
			li_q        <= 24'd1000;
			lw_q        <= 24'd100;
			di_q        <= 24'd60000;
			last_q      <= '0;
			phase_q     <= 1'b0;
			act_q       <= '0;
			slp_q       <= '0;
			sc_q        <= '0;
			duty_q      <= DUTY_FULL;
			est_q       <= ACTIVE_UA;
		end else begin
			state_q <= state_nx;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (in_take)
				last_q <= (mode == KIND_TICK) ? now_ms : last_q;
			if (cfg_take) begin
				case (cfg_idx_t'(cfg_index))
					CFG_POWER_MODE: begin
						pm_q    <= cfg_data[1:0];
						phase_q <= 1'b0;
					end
					CFG_LIGHT_INTERVAL: li_q <= cfg_data;
					CFG_LIGHT_WINDOW:   lw_q <= cfg_data;
					CFG_DEEP_INTERVAL:  di_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_DISP) begin
				if (kind_q == KIND_TICK) begin
					if (advanced && !light_go) begin
						act_q <= act_q + COUNT_WIDTH'(now_q - a_q);
						if (pm_q == PM_ACTIVE || !end_node)
							phase_q <= 1'b0;
					end
				end else if (deep_ok && grad_q) begin
					sc_q  <= sc_q + COUNT_WIDTH'(1);
					slp_q <= slp_q + COUNT_WIDTH'(di_q);
				end
			end
			if (state_q == S_LFIN) begin
				act_q   <= act_q + COUNT_WIDTH'(act_add);
				slp_q   <= slp_q + COUNT_WIDTH'(slp_add);
				sc_q    <= sc_q + COUNT_WIDTH'(sl_all);
				phase_q <= me1 >= eff_w;
			end
			if (state_q == S_DUTY_WAIT && duty_stat.done)
				duty_q <= duty_res;
			if (state_q == S_EST_BASE && pm_q == PM_ACTIVE)
				est_q <= ACTIVE_UA;
			if (state_q == S_EST_WAIT && div_stat.done)
				est_q <= div_quot[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_q <= mode;
			now_q  <= now_ms;
			role_q <= node_role;
			grad_q <= routing_is_gradient;
			a_q    <= last_q;
		end
		if (state_q == S_DISP) begin
			delta_q      <= now_q - a_q;
			res_status_q <= STAT_OK;
			res_sl_q     <= '0;
			res_wk_q     <= '0;
			res_req_q    <= '0;
			if (kind_q != KIND_TICK) begin
				if (!deep_ok)
					res_status_q <= STAT_BAD_ROLE;
				else if (!grad_q)
					res_status_q <= STAT_NO_ROUTE;
				else begin
					res_sl_q  <= 8'd1;
					res_req_q <= di_q;
				end
			end
		end
		if (state_q == S_DIV_A && div_stat.done) begin
			qa_q <= div_quot[31:0];
			ma_q <= div_rem;
		end
		if (state_q == S_DIV_E && div_stat.done) begin
			qe_q <= div_quot[31:0];
			me_q <= div_rem;
		end
		if (state_q == S_LPREP) begin
			qa1_q <= qa_q + 32'(wrap_a);
			ma1_q <= wrap_a ? '0 : ma_q + 24'd1;
		end
		if (state_q == S_LFIN) begin
			res_sl_q <= (sl_all[33:8] != '0) ? 8'hFF : sl_all[7:0];
			res_wk_q <= (wk_all[33:8] != '0) ? 8'hFF : wk_all[7:0];
		end
		if (state_q == S_EST_BASE)
			base_q <= (pm_q == PM_LIGHT) ? 29'(eff_i) + 29'(eff_w) * LIGHT_RATIO : 29'(deep_s);
		if (state_q == S_EST_NUM) begin
			est_num_q <= (pm_q == PM_LIGHT) ? 40'(base_q) * LIGHT_SLEEP_UA :
				DEEP_TX_CHARGE + 40'(base_q) * DEEP_SLEEP_UA;
			est_den_q <= (pm_q == PM_LIGHT) ? eff_i :
				((di_q > DEEP_TX_MS) ? di_q : DEEP_TX_MS);
		end
		if (out_load) begin
			o_status_q <= res_status_q;
			o_sl_q     <= res_sl_q;
			o_wk_q     <= res_wk_q;
			o_req_q    <= res_req_q;
			o_total_q  <= 32'(sc_q);
			o_act_q    <= 32'(act_q);
			o_slp_q    <= 32'(slp_q);
			o_duty_q   <= duty_q;
			o_est_q    <= est_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = o_status_q;
	assign sleep_events      = o_sl_q;
	assign wake_events       = o_wk_q;
	assign sleep_request_ms  = o_req_q;
	assign sleep_total       = o_total_q;
	assign active_time_ms    = o_act_q;
	assign sleep_time_ms     = o_slp_q;
	assign duty_basis_points = o_duty_q;
	assign estimated_ua      = o_est_q;

	`DCPA_ASSERT(a_duty_range, duty_q <= DUTY_FULL, "duty above full scale")
	`DCPA_ASSERT(a_idle_units, (state_q != S_IDLE) || !(div_stat.busy || mul_stat.busy || duty_stat.busy), "unit busy while idle")
	`DCPA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready && !cfg_ready, "beat taken while item open")
endmodule
`default_nettype wire

// File: bench/tb_duty_cycle_power_accountant_unit.sv
// Self-checking testbench of the duty-cycle power accountant: directed and random ticks and requests.
`default_nettype none
module tb_duty_cycle_power_accountant_unit import dcpa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  sleep_events;
		logic [7:0]  wake_events;
		logic [23:0] sleep_request_ms;
		logic [31:0] sleep_total;
		logic [31:0] active_time_ms;
		logic [31:0] sleep_time_ms;
		logic [13:0] duty_basis_points;
		logic [16:0] estimated_ua;
	} acct_report_t;

	localparam logic KIND_REQ = 1'b1;
	localparam logic [1:0] PM_DEEP = 2'd2;
	localparam logic [1:0] PM_THREE = 2'd3;
	localparam logic [1:0] ROLE_ROUTER = 2'd1;
	localparam logic [1:0] ROLE_COORD = 2'd2;
	localparam logic [1:0] ROLE_THREE = 2'd3;

	logic clk, arst_n;
	logic in_valid, in_ready, mode, routing_is_gradient;
	logic [31:0] now_ms;
	logic [1:0] node_role;
	logic out_valid, out_ready;
	logic [1:0] status;
	logic [7:0] sleep_events, wake_events;
	logic [23:0] sleep_request_ms;
	logic [31:0] sleep_total, active_time_ms, sleep_time_ms;
	logic [13:0] duty_basis_points;
	logic [16:0] estimated_ua;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	duty_cycle_power_accountant_unit uut (.*);

	// predictor state
	logic [1:0]  pm;
	logic [23:0] l_int, l_win, d_int;
	logic [31:0] stamp;
	logic        asleep;
	logic [31:0] act_acc, slp_acc, slp_cnt;
	logic [13:0] duty_q;
	logic [16:0] est_q;

	acct_report_t reports_due[$];
	int errors, n_items, n_checked, n_ticks, n_reqs;
	logic [31:0] cur_ms;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [63:0] eff_int();
		return (l_int == 0) ? 64'd1000 : 64'(l_int);
	endfunction

	function automatic logic [63:0] eff_win();
		logic [63:0] i;
		i = eff_int();
		return (64'(l_win) > i) ? i : 64'(l_win);
	endfunction

	function automatic logic [16:0] current_ua();
		logic [63:0] i, w, s;
		if (pm == PM_ACTIVE) return 17'd60000;
		if (pm == PM_LIGHT) begin
			i = eff_int();
			w = eff_win();
			return 17'((w * 60000 + (i - w) * 2000) / i);
		end
		s = (d_int > 500) ? 64'(d_int) - 500 : 0;
		return 17'((64'd40000000 + s * 10) / (500 + s));
	endfunction

	function automatic logic [13:0] duty_of(logic [31:0] a, logic [31:0] t);
		if (t == 0 || a >= t) return 14'd10000;
		return 14'((64'(a) * 10000) / 64'(t));
	endfunction

	function automatic logic [63:0] below_cnt(logic [63:0] x, logic [63:0] i, logic [63:0] w);
		logic [63:0] m;
		m = x % i;
		return (x / i) * w + ((m < w) ? m : w);
	endfunction

	function automatic logic [63:0] hits(logic [63:0] x, logic [63:0] i, logic [63:0] k);
		return x / i + (((x % i) > k) ? 1 : 0);
	endfunction

	task automatic predict(input logic kind, input logic [31:0] t, input logic [1:0] role,
			input logic grad);
		acct_report_t r;
		logic [63:0] i, w, a, e, act, sl, wk;
		r = '0;
		sl = 0;
		wk = 0;
		if (kind == KIND_TICK) begin
			if (t > stamp) begin
				if (pm == PM_ACTIVE || role != ROLE_END) begin
					act_acc += t - stamp;
					asleep = 0;
				end else if (pm == PM_LIGHT) begin
					i = eff_int();
					w = eff_win();
					a = 64'(stamp);
					e = 64'(t);
					act = below_cnt(e, i, w) - below_cnt(a, i, w);
					if ((a % i) < w) begin
						if (asleep) wk++;
					end else if (!asleep) sl++;
					if (w > 0 && w < i) begin
						wk += hits(e, i, 0) - hits(a + 1, i, 0);
						sl += hits(e, i, w) - hits(a + 1, i, w);
					end
					asleep = ((e - 1) % i) >= w;
					act_acc += 32'(act);
					slp_acc += 32'((e - a) - act);
					slp_cnt += 32'(sl);
				end else act_acc += t - stamp;
			end
			stamp = t;
			duty_q = duty_of(act_acc, act_acc + slp_acc);
			est_q = current_ua();
		end else begin
			if (pm < PM_DEEP || role != ROLE_END) r.status = STAT_BAD_ROLE;
			else if (!grad) r.status = STAT_NO_ROUTE;
			else begin
				slp_cnt++;
				slp_acc += d_int;
				sl = 1;
				r.sleep_request_ms = d_int;
			end
		end
		r.sleep_events = (sl > 255) ? 8'd255 : 8'(sl);
		r.wake_events = (wk > 255) ? 8'd255 : 8'(wk);
		r.sleep_total = slp_cnt;
		r.active_time_ms = act_acc;
		r.sleep_time_ms = slp_acc;
		r.duty_basis_points = duty_q;
		r.estimated_ua = est_q;
		reports_due.push_back(r);
	endtask

	task automatic send_item(input logic kind, input logic [31:0] t, input logic [1:0] role,
			input logic grad);
		int gap;
		gap = $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 0;
			mode <= 1'($urandom);
			now_ms <= $urandom;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		mode <= kind;
		now_ms <= t;
		node_role <= role;
		routing_is_gradient <= grad;
		do @(posedge clk); while (!in_ready);
		predict(kind, t, role, grad);
		n_items++;
		if (kind == KIND_TICK) n_ticks++; else n_reqs++;
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		in_valid <= 0;
		guard = 0;
		while (reports_due.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (250) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_POWER_MODE: begin
				pm = val[1:0];
				asleep = 0;
			end
			CFG_LIGHT_INTERVAL: l_int = val;
			CFG_LIGHT_WINDOW: l_win = val;
			CFG_DEEP_INTERVAL: d_int = val;
			default: ;
		endcase
		est_q = current_ua();
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic tick_ahead(input logic [31:0] step, input logic [1:0] role);
		cur_ms += step;
		send_item(KIND_TICK, cur_ms, role, 1'($urandom));
	endtask

	task automatic test_active_mode();
		send_item(KIND_TICK, 0, ROLE_END, 0);
		send_item(KIND_TICK, 32'hFFFF_FFFF, ROLE_END, 1);
		send_item(KIND_TICK, 32'hFFFF_FFFF, ROLE_ROUTER, 0);
		send_item(KIND_TICK, 5, ROLE_THREE, 0);
		send_item(KIND_REQ, 0, ROLE_END, 1);
		send_item(KIND_REQ, 0, ROLE_THREE, 1);
		cur_ms = 10;
		tick_ahead(1, ROLE_COORD);
	endtask

	task automatic test_light_mode();
		write_reg(CFG_POWER_MODE, 24'(PM_LIGHT));
		write_reg(CFG_LIGHT_INTERVAL, 10);
		write_reg(CFG_LIGHT_WINDOW, 3);
		tick_ahead(1, ROLE_END);
		tick_ahead(4, ROLE_END);
		tick_ahead(37, ROLE_END);
		tick_ahead(2000, ROLE_END);
		tick_ahead(0, ROLE_END);
		tick_ahead(9, ROLE_ROUTER);
		write_reg(CFG_LIGHT_WINDOW, 0);
		tick_ahead(25, ROLE_END);
		write_reg(CFG_LIGHT_WINDOW, 24'hFFFFFF);
		tick_ahead(25, ROLE_END);
		write_reg(CFG_LIGHT_INTERVAL, 0);
		write_reg(CFG_LIGHT_WINDOW, 100);
		tick_ahead(3456, ROLE_END);
		write_reg(CFG_LIGHT_INTERVAL, 24'hFFFFFF);
		tick_ahead(32'h0100_0000, ROLE_END);
		send_item(KIND_REQ, 0, ROLE_END, 1);
	endtask

	task automatic test_deep_mode();
		write_reg(CFG_POWER_MODE, 24'(PM_DEEP));
		write_reg(CFG_DEEP_INTERVAL, 24'hFFFFFF);
		tick_ahead(7, ROLE_END);
		send_item(KIND_REQ, 0, ROLE_END, 1);
		send_item(KIND_REQ, 0, ROLE_END, 0);
		send_item(KIND_REQ, 0, ROLE_ROUTER, 1);
		write_reg(CFG_DEEP_INTERVAL, 0);
		send_item(KIND_REQ, 0, ROLE_END, 1);
		write_reg(CFG_DEEP_INTERVAL, 300);
		write_reg(CFG_POWER_MODE, 24'(PM_THREE));
		send_item(KIND_REQ, 0, ROLE_END, 1);
		tick_ahead(3, ROLE_END);
	endtask

	task automatic test_random();
		int k, j;
		for (k = 0; k < 12; k++) begin
			write_reg(CFG_POWER_MODE, 24'($urandom_range(0, 3)));
			write_reg(CFG_LIGHT_INTERVAL,
				24'((k % 4 == 0) ? $urandom : $urandom_range(0, 50)));
			write_reg(CFG_LIGHT_WINDOW,
				24'((k % 3 == 0) ? $urandom : $urandom_range(0, 60)));
			write_reg(CFG_DEEP_INTERVAL,
				24'((k % 5 == 0) ? $urandom : $urandom_range(0, 2000)));
			for (j = 0; j < 48; j++) begin
				case ($urandom_range(0, 9))
					0: send_item(KIND_TICK, $urandom, 2'($urandom), 1'($urandom));
					1, 2: send_item(KIND_REQ, $urandom, $urandom_range(0, 3) == 0 ?
						2'($urandom) : ROLE_END, $urandom_range(0, 3) != 0);
					3: tick_ahead($urandom,
						$urandom_range(0, 5) == 0 ? 2'($urandom) : ROLE_END);
					default: tick_ahead($urandom_range(0, 200),
						$urandom_range(0, 5) == 0 ? 2'($urandom) : ROLE_END);
				endcase
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		acct_report_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {status, sleep_events, wake_events, sleep_request_ms, sleep_total,
				active_time_ms, sleep_time_ms, duty_basis_points, estimated_ua};
			if (reports_due.size() == 0) begin
				$display("%t: unexpected result beat %p", $realtime, got);
				errors++;
			end else begin
				want = reports_due.pop_front();
				n_checked++;
				if (got != want) begin
					$display("%t: mismatch expected %p actual %p", $realtime, want, got);
					errors++;
				end
			end
		end
	end

	// result side: random wait before each beat
	initial begin
		int idle_n;
		out_ready = 0;
		forever begin
			idle_n = $urandom_range(0, 10);
			if (idle_n != 0) begin
				out_ready <= 0;
				repeat (idle_n) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!(arst_n && out_valid));
			@(negedge clk);
		end
	end

	initial begin
		errors = 0;
		n_items = 0;
		n_checked = 0;
		n_ticks = 0;
		n_reqs = 0;
		arst_n = 0;
		in_valid = 0;
		mode = 0;
		now_ms = 0;
		node_role = 0;
		routing_is_gradient = 0;
		cfg_valid = 0;
		cfg_index = CFG_POWER_MODE;
		cfg_data = 0;
		pm = PM_ACTIVE;
		l_int = 1000;
		l_win = 100;
		d_int = 60000;
		stamp = 0;
		asleep = 0;
		act_acc = 0;
		slp_acc = 0;
		slp_cnt = 0;
		duty_q = 10000;
		est_q = 60000;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_active_mode();
		test_light_mode();
		test_deep_mode();
		test_random();
		drain();
		$display("Covered %0d items (%0d ticks, %0d requests), %0d results checked",
			n_items, n_ticks, n_reqs, n_checked);
		$display("across active, light and deep modes with boundary register values.");
		if (errors == 0 && reports_due.size() == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
